@@ rtl/udrb_pkg.sv @@
`timescale 1ns / 1ps

package udrb_pkg;

  localparam int RING_DEPTH = 8;
  localparam int PTR_W      = (RING_DEPTH > 2) ? $clog2(RING_DEPTH) : 1;
  localparam int LVL_W      = $clog2(RING_DEPTH + 1);
  localparam int DATA_W     = 8;
  localparam int OP_W       = 3;
  localparam int S_TDATA_W  = ((DATA_W + 7) / 8) * 8;
  localparam int M_FIELDS_W = DATA_W + 3 + 2 * LVL_W;
  localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;
  localparam int M_PAD_W    = M_TDATA_W - M_FIELDS_W;

  typedef enum logic [OP_W-1:0] {
    OP_TX_PUSH  = 3'd0,
    OP_RX_POP   = 3'd1,
    OP_RX_WRITE = 3'd2,
    OP_TX_READY = 3'd3,
    OP_RX_FLUSH = 3'd4,
    OP_TX_FLUSH = 3'd5
  } opcode_t;

  typedef struct packed {
    logic             we;
    logic             re;
    logic [PTR_W-1:0] addr;
  } ram_cmd_t;

  typedef struct packed {
    logic             rd;
    logic             sel_rx;
    logic             accepted;
    logic             overrun;
    logic [LVL_W-1:0] rx_level;
    logic [LVL_W-1:0] tx_level;
    logic             tx_active;
  } res_meta_t;

endpackage

@@ rtl/uart_dual_ring_buffer.sv @@
`timescale 1ns / 1ps

// UART transmit and receive byte rings, each held in a small synchronous RAM
// with a registered read port. Each input word is one command (opcode in
// s_tuser, byte in s_tdata) and yields exactly one output word with the
// popped byte, status flags and both ring levels after the command. A
// command goes from acceptance to its output word through the RAM access
// and pointer update, then the result register, and the output may stall
// between them. Words are accepted every cycle while the output side keeps
// up; a waiting output word still lets one command into an empty RAM stage,
// after which input stalls. Pointers and fills live in flops and update at
// acceptance, so back-to-back commands on the same ring see each other with
// no forwarding. Ring contents are not cleared by reset or flush.
module uart_dual_ring_buffer (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // data_in
  input  logic [udrb_pkg::S_TDATA_W-1:0]   s_tdata,
  // opcode
  input  logic [udrb_pkg::OP_W-1:0]        s_tuser,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // data_out, push_accepted, rx_overrun, rx_level, tx_level, tx_active
  output logic [udrb_pkg::M_TDATA_W-1:0]   m_tdata,
  // data_valid
  output logic                             m_tuser
);

  logic                        in_fire;
  logic                        advance;
  logic                        p_valid;
  udrb_pkg::ram_cmd_t          tx_cmd, rx_cmd;
  udrb_pkg::res_meta_t         meta, out_meta;
  logic [udrb_pkg::DATA_W-1:0] tx_rdata, rx_rdata, out_data;

  assign advance  = p_valid && (!m_tvalid || m_tready);
  assign s_tready = !p_valid || advance;
  assign in_fire  = s_tvalid && s_tready;

  udrb_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_fire (in_fire),
    .opcode  (s_tuser),
    .advance (advance),
    .tx_cmd  (tx_cmd),
    .rx_cmd  (rx_cmd),
    .p_valid (p_valid),
    .meta    (meta)
  );

  udrb_ram #(
    .DEPTH (udrb_pkg::RING_DEPTH),
    .WIDTH (udrb_pkg::DATA_W),
    .ADDR_W(udrb_pkg::PTR_W)
  ) u_tx_ram (
    .clk   (clk),
    .we    (tx_cmd.we),
    .re    (tx_cmd.re),
    .addr  (tx_cmd.addr),
    .wdata (s_tdata[udrb_pkg::DATA_W-1:0]),
    .rdata (tx_rdata)
  );

  udrb_ram #(
    .DEPTH (udrb_pkg::RING_DEPTH),
    .WIDTH (udrb_pkg::DATA_W),
    .ADDR_W(udrb_pkg::PTR_W)
  ) u_rx_ram (
    .clk   (clk),
    .we    (rx_cmd.we),
    .re    (rx_cmd.re),
    .addr  (rx_cmd.addr),
    .wdata (s_tdata[udrb_pkg::DATA_W-1:0]),
    .rdata (rx_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // zero the byte unless a pop produced it
  always_ff @(posedge clk) begin
    if (advance) begin
      out_meta <= meta;
      if (!meta.rd) begin
        out_data <= '0;
      end else if (meta.sel_rx) begin
        out_data <= rx_rdata;
      end else begin
        out_data <= tx_rdata;
      end
    end
  end

  assign m_tdata = {{udrb_pkg::M_PAD_W{1'b0}}, out_meta.tx_active, out_meta.tx_level,
                    out_meta.rx_level, out_meta.overrun, out_meta.accepted, out_data};
  assign m_tuser = out_meta.rd;

endmodule

@@ rtl/udrb_ram.sv @@
`timescale 1ns / 1ps

module udrb_ram #(
  parameter int DEPTH  = 8,
  parameter int WIDTH  = 8,
  parameter int ADDR_W = (DEPTH > 2) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic              re,
  input  logic [ADDR_W-1:0] addr,
  input  logic [WIDTH-1:0]  wdata,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

@@ rtl/udrb_ctrl.sv @@
`timescale 1ns / 1ps

module udrb_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_fire,
  input  logic [udrb_pkg::OP_W-1:0]  opcode,
  input  logic                       advance,
  output udrb_pkg::ram_cmd_t         tx_cmd,
  output udrb_pkg::ram_cmd_t         rx_cmd,
  output logic                       p_valid,
  output udrb_pkg::res_meta_t        meta
);

  localparam logic [udrb_pkg::LVL_W-1:0] FULL = udrb_pkg::LVL_W'(udrb_pkg::RING_DEPTH);
  localparam logic [udrb_pkg::PTR_W-1:0] LAST = udrb_pkg::PTR_W'(udrb_pkg::RING_DEPTH - 1);

  logic [udrb_pkg::PTR_W-1:0] tx_head, tx_head_next, tx_tail, tx_tail_next;
  logic [udrb_pkg::PTR_W-1:0] rx_head, rx_head_next, rx_tail, rx_tail_next;
  logic [udrb_pkg::LVL_W-1:0] tx_fill, tx_fill_next, rx_fill, rx_fill_next;
  logic                       tx_flag, tx_flag_next;
  udrb_pkg::res_meta_t        meta_next;

  function automatic logic [udrb_pkg::PTR_W-1:0] wrap_inc(
    input logic [udrb_pkg::PTR_W-1:0] p
  );
    return (p == LAST) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    tx_head_next = tx_head;
    tx_tail_next = tx_tail;
    tx_fill_next = tx_fill;
    rx_head_next = rx_head;
    rx_tail_next = rx_tail;
    rx_fill_next = rx_fill;
    tx_flag_next = tx_flag;
    tx_cmd       = '0;
    rx_cmd       = '0;
    meta_next    = '0;
    case (udrb_pkg::opcode_t'(opcode))
      udrb_pkg::OP_TX_PUSH: begin
        if (tx_fill != FULL) begin
          tx_cmd.we          = 1'b1;
          tx_cmd.addr        = tx_tail;
          tx_tail_next       = wrap_inc(tx_tail);
          tx_fill_next       = tx_fill + 1'b1;
          tx_flag_next       = 1'b1;
          meta_next.accepted = 1'b1;
        end
      end
      udrb_pkg::OP_RX_POP: begin
        if (rx_fill != '0) begin
          rx_cmd.re        = 1'b1;
          rx_cmd.addr      = rx_head;
          rx_head_next     = wrap_inc(rx_head);
          rx_fill_next     = rx_fill - 1'b1;
          meta_next.rd     = 1'b1;
          meta_next.sel_rx = 1'b1;
        end
      end
      udrb_pkg::OP_RX_WRITE: begin
        rx_cmd.we    = 1'b1;
        rx_cmd.addr  = rx_tail;
        rx_tail_next = wrap_inc(rx_tail);
        if (rx_fill != FULL) begin
          rx_fill_next = rx_fill + 1'b1;
        end else begin
          rx_head_next      = wrap_inc(rx_head);
          meta_next.overrun = 1'b1;
        end
      end
      udrb_pkg::OP_TX_READY: begin
        if (tx_fill != '0) begin
          tx_cmd.re    = 1'b1;
          tx_cmd.addr  = tx_head;
          tx_head_next = wrap_inc(tx_head);
          tx_fill_next = tx_fill - 1'b1;
          meta_next.rd = 1'b1;
        end
        if (tx_fill_next == '0) begin
          tx_flag_next = 1'b0;
        end
      end
      udrb_pkg::OP_RX_FLUSH: begin
        rx_head_next = '0;
        rx_tail_next = '0;
        rx_fill_next = '0;
      end
      udrb_pkg::OP_TX_FLUSH: begin
        tx_head_next = '0;
        tx_tail_next = '0;
        tx_fill_next = '0;
      end
      default: begin
      end
    endcase
    meta_next.rx_level  = rx_fill_next;
    meta_next.tx_level  = tx_fill_next;
    meta_next.tx_active = tx_flag_next;
    if (!in_fire) begin
      tx_cmd = '0;
      rx_cmd = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tx_head <= '0;
      tx_tail <= '0;
      tx_fill <= '0;
      rx_head <= '0;
      rx_tail <= '0;
      rx_fill <= '0;
      tx_flag <= 1'b0;
      p_valid <= 1'b0;
    end else begin
      if (in_fire) begin
        tx_head <= tx_head_next;
        tx_tail <= tx_tail_next;
        tx_fill <= tx_fill_next;
        rx_head <= rx_head_next;
        rx_tail <= rx_tail_next;
        rx_fill <= rx_fill_next;
        tx_flag <= tx_flag_next;
        p_valid <= 1'b1;
      end else if (advance) begin
        p_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      meta <= meta_next;
    end
  end

endmodule

@@ rtl/udrb_chk.sv @@
`timescale 1ns / 1ps

module udrb_chk (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_tvalid,
  input logic                           s_tready,
  input logic [udrb_pkg::S_TDATA_W-1:0] s_tdata,
  input logic [udrb_pkg::OP_W-1:0]      s_tuser,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [udrb_pkg::M_TDATA_W-1:0] m_tdata,
  input logic                           m_tuser
);

  localparam int RXL = udrb_pkg::DATA_W + 2;
  localparam int TXL = RXL + udrb_pkg::LVL_W;
  localparam int ACT = TXL + udrb_pkg::LVL_W;
  localparam logic [udrb_pkg::LVL_W-1:0] FULL = udrb_pkg::LVL_W'(udrb_pkg::RING_DEPTH);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("output word changed while stalled");

  a_zero_byte: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata[udrb_pkg::DATA_W-1:0] == '0)
    else $error("data byte nonzero without data_valid");

  a_one_event: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> $countones({m_tuser, m_tdata[udrb_pkg::DATA_W+1:udrb_pkg::DATA_W]}) <= 1)
    else $error("more than one event flag in a word");

  a_levels: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[TXL-1:RXL] <= FULL && m_tdata[ACT-1:TXL] <= FULL)
    else $error("ring level out of range");

  a_push_active: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[udrb_pkg::DATA_W] |-> m_tdata[ACT] && m_tdata[ACT-1:TXL] != '0)
    else $error("accepted push without tx active and nonzero tx level");

endmodule

bind uart_dual_ring_buffer udrb_chk u_udrb_chk (.*);
